// ===== rtl/tss_pkg.sv =====
// Package for the task slot scheduler: sizes, command codes, operation
// classes, state encoding and the request record passed from front to back.
// No dependencies.
`default_nettype none
package tss_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int Q_DEPTH   = 2;
    localparam int Q_PW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] PRIO_LIMIT = 8'd100;
    localparam logic [SLOT_W-1:0] FIRST_USER_SLOT = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] LAST_SLOT       = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [CNT_W-1:0]  SCAN_ALL        = CNT_W'(NUM_SLOTS);
    localparam logic [CNT_W-1:0]  SCAN_USER       = CNT_W'(NUM_SLOTS - 2);

    localparam logic [2:0] CMD_ADD        = 3'd0;
    localparam logic [2:0] CMD_REMOVE     = 3'd1;
    localparam logic [2:0] CMD_SET_READY  = 3'd2;
    localparam logic [2:0] CMD_PICK_PRIO  = 3'd3;
    localparam logic [2:0] CMD_PICK_NEXT  = 3'd4;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_REMOVE,
        OP_SET_READY,
        OP_PICK_PRIO,
        OP_PICK_NEXT,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POST
    } t_state;

    typedef struct packed {
        t_op        op;
        t_slot      slot;
        logic       idx_ok;
        logic [7:0] prio;
        logic       rdy;
    } t_req;

endpackage
`default_nettype wire

// ===== rtl/tss_front.sv =====
// Front end: takes requests and classifies them into queue records.
// Depends on tss_pkg.
`default_nettype none
module tss_front (
    input  wire logic          i_in_valid,
    input  wire logic [2:0]    i_command,
    input  wire logic [3:0]    i_slot_index,
    input  wire logic [7:0]    i_task_priority,
    input  wire logic          i_ready_flag,
    input  wire logic          i_full,
    output logic               o_in_stall,
    output logic               o_push,
    output tss_pkg::t_req      o_req
);
    import tss_pkg::*;

    t_op n_op;

    always_comb begin
        case (i_command)
            CMD_ADD:       n_op = OP_ADD;
            CMD_REMOVE:    n_op = OP_REMOVE;
            CMD_SET_READY: n_op = OP_SET_READY;
            CMD_PICK_PRIO: n_op = OP_PICK_PRIO;
            CMD_PICK_NEXT: n_op = OP_PICK_NEXT;
            default:       n_op = OP_NOP;
        endcase
    end

    always_comb begin
        o_req.op     = n_op;
        o_req.slot   = SLOT_W'(i_slot_index);
        o_req.idx_ok = 32'(i_slot_index) < NUM_SLOTS;
        o_req.prio   = i_task_priority;
        o_req.rdy    = i_ready_flag;
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

endmodule
`default_nettype wire

// ===== rtl/tss_queue.sv =====
// Short request queue between front and back end.
// Depends on tss_pkg.
`default_nettype none
module tss_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tss_pkg::t_req i_req,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output tss_pkg::t_req      o_req
);
    import tss_pkg::*;

    t_req            r_mem [Q_DEPTH];
    logic [Q_PW-1:0] r_wp;
    logic [Q_PW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;

    function automatic logic [Q_PW-1:0] f_inc(input logic [Q_PW-1:0] p);
        f_inc = (32'(p) == Q_DEPTH - 1) ? '0 : p + Q_PW'(1);
    endfunction

    assign o_full  = r_cnt == Q_CW'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= f_inc(r_wp);
            if (i_pop)  r_rp <= f_inc(r_rp);
            if (i_push && !i_pop)      r_cnt <= r_cnt + Q_CW'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_req;
    end

endmodule
`default_nettype wire

// ===== rtl/tss_back.sv =====
// Back end: slot table, one-slot-per-cycle scanner and result register.
// Depends on tss_pkg.
`default_nettype none
module tss_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire tss_pkg::t_req i_q_req,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [3:0]         o_chosen_slot,
    output logic               o_found
);
    import tss_pkg::*;

    t_state r_state, n_state;

    logic [NUM_SLOTS-1:0] r_occ;
    logic [NUM_SLOTS-1:0] r_rdy;
    logic [7:0]           r_prio_mem [NUM_SLOTS];
    t_slot                r_cur;
    logic                 r_cur_vld;

    t_op        r_op;
    t_req       r_req;
    t_slot      r_idx;
    logic [CNT_W-1:0] r_left;
    logic       r_p_vld;
    t_slot      r_p_idx;
    logic [7:0] r_p_prio;
    logic [7:0] r_best;
    t_slot      r_hit;
    logic       r_found;
    t_slot      r_res_slot;
    logic       r_res_found;
    logic       r_o_valid;
    logic [3:0] r_o_slot;
    logic       r_o_found;

    logic       out_free;
    logic       load_out;
    logic       is_scan;
    t_slot      start_idx;
    logic [CNT_W-1:0] start_left;
    t_slot      nxt_idx;
    logic       p_occ;
    logic       p_elig;
    logic       stop_hit;
    logic       prio_better;
    logic       scan_end;
    logic       end_found;
    t_slot      end_slot;
    logic       q_hit;

    assign out_free = !r_o_valid || !i_out_stall;

    always_comb begin
        is_scan    = 1'b0;
        start_idx  = '0;
        start_left = '0;
        case (i_q_req.op)
            OP_ADD: begin
                is_scan    = 1'b1;
                start_left = SCAN_ALL;
            end
            OP_PICK_PRIO: begin
                is_scan    = 1'b1;
                start_idx  = FIRST_USER_SLOT;
                start_left = SCAN_USER;
            end
            OP_PICK_NEXT: begin
                is_scan    = 1'b1;
                start_idx  = (r_cur == LAST_SLOT) ? FIRST_USER_SLOT : r_cur + SLOT_W'(1);
                start_left = r_cur_vld ? SCAN_USER : '0;
            end
            default: begin
                is_scan = 1'b0;
            end
        endcase
    end

    assign nxt_idx     = (r_idx == LAST_SLOT) ? FIRST_USER_SLOT : r_idx + SLOT_W'(1);
    assign p_occ       = r_occ[r_p_idx];
    assign p_elig      = p_occ && r_rdy[r_p_idx];
    assign stop_hit    = r_p_vld && ((r_op == OP_ADD && !p_occ)
                                     || (r_op == OP_PICK_NEXT && p_elig));
    assign prio_better = r_p_vld && r_op == OP_PICK_PRIO && p_elig && r_p_prio < r_best;
    assign scan_end    = stop_hit || (r_left == '0 && !r_p_vld);
    assign end_found   = stop_hit || r_found;
    assign end_slot    = stop_hit ? r_p_idx : (r_found ? r_hit : '0);
    assign q_hit       = i_q_req.idx_ok && r_occ[i_q_req.slot];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_q_valid) n_state = is_scan ? S_SCAN : S_POST;
            S_SCAN: if (scan_end) n_state = S_POST;
            S_POST: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            S_IDLE:  o_pop = i_q_valid;
            S_POST:  load_out = out_free;
            default: o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_occ     <= '0;
            r_rdy     <= '0;
            r_cur     <= '0;
            r_cur_vld <= 1'b0;
            r_left    <= '0;
            r_p_vld   <= 1'b0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_left  <= start_left;
                r_p_vld <= 1'b0;
                r_found <= 1'b0;
                case (i_q_req.op)
                    OP_REMOVE: begin
                        if (q_hit) begin
                            r_occ[i_q_req.slot] <= 1'b0;
                            r_rdy[i_q_req.slot] <= 1'b0;
                            if (r_cur_vld && r_cur == i_q_req.slot) r_cur_vld <= 1'b0;
                        end
                    end
                    OP_SET_READY: begin
                        if (q_hit) r_rdy[i_q_req.slot] <= i_q_req.rdy;
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == S_SCAN) begin
                r_p_vld <= r_left != '0;
                if (r_left != '0) r_left <= r_left - CNT_W'(1);
                if (prio_better) r_found <= 1'b1;
                if (stop_hit && r_op == OP_ADD) begin
                    r_occ[r_p_idx] <= 1'b1;
                    r_rdy[r_p_idx] <= r_req.rdy;
                end
                if (scan_end && r_op != OP_ADD && end_found) begin
                    r_cur     <= end_slot;
                    r_cur_vld <= 1'b1;
                end
            end
            if (load_out) r_o_valid <= 1'b1;
            else if (!i_out_stall) r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op        <= i_q_req.op;
            r_req       <= i_q_req;
            r_idx       <= start_idx;
            r_best      <= PRIO_LIMIT;
            r_res_slot  <= '0;
            r_res_found <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            if (r_left != '0) r_idx <= nxt_idx;
            r_p_idx <= r_idx;
            if (prio_better) begin
                r_best <= r_p_prio;
                r_hit  <= r_p_idx;
            end
            if (scan_end) begin
                r_res_slot  <= end_slot;
                r_res_found <= end_found;
            end
        end
        if (load_out) begin
            r_o_slot  <= 4'(r_res_slot);
            r_o_found <= r_res_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && stop_hit && r_op == OP_ADD) r_prio_mem[r_p_idx] <= r_req.prio;
        r_p_prio <= r_prio_mem[r_idx];
    end

    assign o_out_valid   = r_o_valid;
    assign o_chosen_slot = r_o_slot;
    assign o_found       = r_o_found;

endmodule
`default_nettype wire

// ===== rtl/task_slot_scheduler.sv =====
// Task slot scheduler: a table of NUM_SLOTS slots with add, remove, set_ready,
// priority pick and round-robin pick. Each request returns one result. Requests
// enter a two-entry queue; the back end walks the slot table one slot per cycle
// through a registered priority memory read. Remove, set_ready and unknown
// commands skip the scan and go from dequeue to the result register; add and
// the picks scan the slot table before their result is loaded.
// Depends on tss_pkg, tss_front, tss_queue, tss_back.
`default_nettype none
module task_slot_scheduler (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [2:0] i_command,
    input  wire logic [3:0] i_slot_index,
    input  wire logic [7:0] i_task_priority,
    input  wire logic       i_ready_flag,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [3:0]      o_chosen_slot,
    output logic            o_found
);
    import tss_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic q_valid;
    t_req f_req;
    t_req q_req;

    tss_front u_front (
        .i_in_valid      (i_in_valid),
        .i_command       (i_command),
        .i_slot_index    (i_slot_index),
        .i_task_priority (i_task_priority),
        .i_ready_flag    (i_ready_flag),
        .i_full          (full),
        .o_in_stall      (o_in_stall),
        .o_push          (push),
        .o_req           (f_req)
    );

    tss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (f_req),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_req   (q_req)
    );

    tss_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_req       (q_req),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_chosen_slot (o_chosen_slot),
        .o_found       (o_found)
    );

endmodule
`default_nettype wire

// ===== rtl/tss_checker.sv =====
// Port-level checks for the task slot scheduler, bound to the top level.
// Depends on task_slot_scheduler.
`default_nettype none
module tss_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [3:0] o_chosen_slot,
    input wire logic       o_found
);

    a_no_result_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result present right after reset");

    a_ready_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_in_stall)
        else $error("request side stalled right after reset");

    a_miss_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_chosen_slot == 4'd0)
        else $error("nonzero slot on a miss");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_chosen_slot) && $stable(o_found))
        else $error("stalled result changed");

endmodule

bind task_slot_scheduler tss_checker u_tss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_chosen_slot (o_chosen_slot),
    .o_found       (o_found)
);
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for task_slot_scheduler: directed and random request traffic.
// It checks each result against a predictor of the slot table.
// Depends on tss_pkg and the task_slot_scheduler RTL.
`timescale 1ns / 100ps
module tb_top;
    import tss_pkg::*;

    localparam logic [2:0] CMD_RSVD_FIRST = CMD_PICK_NEXT + 3'd1;
    localparam logic [2:0] CMD_RSVD_LAST  = '1;
    localparam int         RSVD_WEIGHT    = 3;
    localparam int         SETTLE_CYCLES  = NUM_SLOTS + 12;
    localparam int         DRAIN_LIMIT    = 20000;

    typedef struct packed {
        logic [3:0] slot;
        logic       found;
    } sched_result_t;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_in_valid      = 1'b0;
    logic [2:0] i_command       = CMD_ADD;
    logic [3:0] i_slot_index    = '0;
    logic [7:0] i_task_priority = '0;
    logic       i_ready_flag    = 1'b0;
    logic       i_out_stall     = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [3:0] o_chosen_slot;
    logic       o_found;

    // predicted slot table
    logic [NUM_SLOTS-1:0] occ      = '0;
    logic [NUM_SLOTS-1:0] rdy      = '0;
    logic [7:0]           prio_tab [NUM_SLOTS];
    int                   cur_slot = 0;
    logic                 cur_valid = 1'b0;

    sched_result_t pending_results[$];
    logic          steady          = 1'b0;
    int            errors          = 0;
    int            requests_sent   = 0;
    int            results_checked = 0;
    int            slots_found     = 0;

    task_slot_scheduler DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_slot_index    (i_slot_index),
        .i_task_priority (i_task_priority),
        .i_ready_flag    (i_ready_flag),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_chosen_slot   (o_chosen_slot),
        .o_found         (o_found)
    );

    always #5 i_clk = ~i_clk;

    function automatic sched_result_t schedule_step(input logic [2:0] cmd,
                                                    input logic [3:0] idx,
                                                    input logic [7:0] prio,
                                                    input logic       ready_in);
        sched_result_t r;
        int hit;
        int best;
        r    = '0;
        hit  = -1;
        best = int'(PRIO_LIMIT);
        case (cmd)
            CMD_ADD: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (hit < 0 && !occ[i]) begin
                        hit = i;
                    end
                end
                if (hit >= 0) begin
                    occ[hit]      = 1'b1;
                    rdy[hit]      = ready_in;
                    prio_tab[hit] = prio;
                    r.slot        = 4'(hit);
                    r.found       = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (int'(idx) < NUM_SLOTS && occ[idx]) begin
                    occ[idx] = 1'b0;
                    rdy[idx] = 1'b0;
                    if (cur_valid && cur_slot == int'(idx)) begin
                        cur_valid = 1'b0;
                    end
                end
            end
            CMD_SET_READY: begin
                if (int'(idx) < NUM_SLOTS && occ[idx]) begin
                    rdy[idx] = ready_in;
                end
            end
            CMD_PICK_PRIO, CMD_PICK_NEXT: begin
                if (cmd == CMD_PICK_PRIO) begin
                    for (int i = int'(FIRST_USER_SLOT); i < NUM_SLOTS; i++) begin
                        if (occ[i] && rdy[i] && int'(prio_tab[i]) < best) begin
                            best = int'(prio_tab[i]);
                            hit  = i;
                        end
                    end
                end else if (cur_valid) begin
                    for (int i = cur_slot + 1; i < NUM_SLOTS; i++) begin
                        if (hit < 0 && occ[i] && rdy[i]) begin
                            hit = i;
                        end
                    end
                    for (int i = int'(FIRST_USER_SLOT); i < NUM_SLOTS; i++) begin
                        if (hit < 0 && occ[i] && rdy[i]) begin
                            hit = i;
                        end
                    end
                end
                if (hit >= 0) begin
                    cur_slot  = hit;
                    cur_valid = 1'b1;
                    r.slot    = 4'(hit);
                    r.found   = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic send_request(input logic [2:0] cmd, input logic [3:0] idx,
                                input logic [7:0] prio, input logic ready_in);
        int gap;
        if (!steady && $urandom_range(99) < 34) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(24, 8) : $urandom_range(4, 1);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_slot_index    <= idx;
        i_task_priority <= prio;
        i_ready_flag    <= ready_in;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(schedule_step(cmd, idx, prio, ready_in));
        requests_sent++;
    endtask

    always @(posedge i_clk) begin
        sched_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: chosen_slot=%0d found=%0b",
                       o_chosen_slot, o_found);
                errors++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.found) slots_found++;
                if (o_chosen_slot !== want.slot) begin
                    $error("chosen_slot: expected %0d, actual %0d", want.slot, o_chosen_slot);
                    errors++;
                end
                if (o_found !== want.found) begin
                    $error("found: expected %0b, actual %0b", want.found, o_found);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= (!steady && $urandom_range(99) < 34);
    end

    function automatic logic [7:0] rand_priority();
        int r;
        r = $urandom_range(99);
        if (r < 40) return 8'($urandom_range(int'(PRIO_LIMIT) + 10, int'(PRIO_LIMIT) - 10));
        if (r < 65) return 8'($urandom_range(20));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [3:0] pick_target_slot();
        int r;
        int used[$];
        r = $urandom_range(99);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (occ[i]) used.push_back(i);
        end
        if (r < 15 && cur_valid) return 4'(cur_slot);
        if (r < 75 && used.size() > 0) return 4'(used[$urandom_range(used.size() - 1)]);
        return 4'($urandom_range(NUM_SLOTS - 1));
    endfunction

    task automatic run_random_traffic(input int n_items, input int w_add, input int w_rem,
                                      input int w_rdy, input int w_prio, input int w_next);
        int total;
        int r;
        logic [2:0] cmd;
        total = w_add + w_rem + w_rdy + w_prio + w_next + RSVD_WEIGHT;
        repeat (n_items) begin
            r = $urandom_range(total - 1);
            if (r < w_add) cmd = CMD_ADD;
            else if (r < w_add + w_rem) cmd = CMD_REMOVE;
            else if (r < w_add + w_rem + w_rdy) cmd = CMD_SET_READY;
            else if (r < w_add + w_rem + w_rdy + w_prio) cmd = CMD_PICK_PRIO;
            else if (r < w_add + w_rem + w_rdy + w_prio + w_next) cmd = CMD_PICK_NEXT;
            else cmd = 3'($urandom_range(CMD_RSVD_LAST, CMD_RSVD_FIRST));
            send_request(cmd, pick_target_slot(), rand_priority(), 1'($urandom_range(1)));
        end
    endtask

    // nothing in the table, no current task
    task automatic test_empty_table();
        send_request(CMD_PICK_NEXT, 4'd0, 8'd0, 1'b1);
        send_request(CMD_PICK_PRIO, 4'd15, 8'd255, 1'b0);
        send_request(CMD_REMOVE, 4'd5, 8'd0, 1'b0);
        send_request(CMD_SET_READY, 4'd3, 8'd0, 1'b1);
        for (int c = int'(CMD_RSVD_FIRST); c <= int'(CMD_RSVD_LAST); c++) begin
            send_request(3'(c), 4'hF, 8'hFF, 1'b1);
        end
    endtask

    // reserved slots, limit of 100, ties and not-ready slots
    task automatic test_priority_pick();
        send_request(CMD_ADD, 4'd0, 8'd255, 1'b1);
        send_request(CMD_ADD, 4'd0, 8'd0, 1'b1);
        send_request(CMD_ADD, 4'd0, PRIO_LIMIT, 1'b1);
        send_request(CMD_ADD, 4'd0, PRIO_LIMIT - 8'd1, 1'b1);
        send_request(CMD_ADD, 4'd0, PRIO_LIMIT - 8'd1, 1'b1);
        send_request(CMD_ADD, 4'd0, 8'd5, 1'b0);
        send_request(CMD_PICK_PRIO, 4'd0, 8'd0, 1'b0);
        send_request(CMD_SET_READY, 4'd5, 8'd0, 1'b1);
        send_request(CMD_PICK_PRIO, 4'd0, 8'd0, 1'b0);
    endtask

    // wrap to the first user slot, removal of the current task
    task automatic test_round_robin();
        send_request(CMD_PICK_NEXT, 4'd0, 8'd0, 1'b0);
        send_request(CMD_PICK_NEXT, 4'd0, 8'd0, 1'b0);
        send_request(CMD_REMOVE, 4'd3, 8'd0, 1'b0);
        send_request(CMD_PICK_NEXT, 4'd0, 8'd0, 1'b0);
        send_request(CMD_SET_READY, 4'd4, 8'd0, 1'b0);
        send_request(CMD_PICK_PRIO, 4'd0, 8'd0, 1'b0);
        send_request(CMD_PICK_NEXT, 4'd0, 8'd0, 1'b0);
    endtask

    task automatic test_table_full();
        while (occ != '1) begin
            send_request(CMD_ADD, 4'($urandom_range(15)), rand_priority(), 1'($urandom_range(1)));
        end
        send_request(CMD_ADD, 4'd0, 8'd1, 1'b1);
        send_request(CMD_REMOVE, 4'd7, 8'd0, 1'b0);
        send_request(CMD_ADD, 4'd0, 8'd50, 1'b1);
        send_request(CMD_PICK_NEXT, 4'd0, 8'd0, 1'b0);
    endtask

    task automatic test_random_fill();
        run_random_traffic(280, 50, 10, 15, 10, 12);
    endtask

    task automatic test_random_steady();
        steady = 1'b1;
        run_random_traffic(280, 25, 20, 20, 15, 15);
        steady = 1'b0;
    endtask

    task automatic test_random_mixed();
        run_random_traffic(350, 25, 20, 20, 15, 15);
    endtask

    task automatic test_random_drain();
        run_random_traffic(250, 10, 45, 15, 12, 12);
    endtask

    task automatic test_random_picks();
        run_random_traffic(250, 20, 15, 15, 25, 25);
    endtask

    initial begin
        int waited;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_priority_pick();
        test_round_robin();
        test_table_full();
        test_random_fill();
        test_random_steady();
        test_random_mixed();
        test_random_drain();
        test_random_picks();
        i_in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests over empty, full and churning tables; %0d results checked.",
                 requests_sent, results_checked);
        $display("%0d adds or picks returned a slot; %0d errors.", slots_found, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout after %0d requests sent.", requests_sent);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
